>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks that compile away when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, cond)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

>>> rtl/core/f3ce_pkg.sv
// ----------------------------------------------------------------------------
// f3ce_pkg
// shared widths, register indexes and types of the f3 coefficient embedder
// ----------------------------------------------------------------------------
`default_nettype none

package f3ce_pkg;

  localparam int COEFF_W       = 12;
  localparam int MAX_MSG_BYTES = 32;
  localparam int NUM_WORDS     = 4;
  localparam int WORD_W        = 64;
  localparam int BYTE_W        = 8;
  localparam int MSG_W         = NUM_WORDS * WORD_W;
  localparam int LEN_W         = 6;
  localparam int BIT_POS_W     = 3;
  localparam int BYTE_IDX_W    = 5;
  localparam int CFG_IDX_W     = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WORD0  = 3'd0,
    REG_WORD1  = 3'd1,
    REG_WORD2  = 3'd2,
    REG_WORD3  = 3'd3,
    REG_LENGTH = 3'd4
  } cfg_reg_t;

  // message bits and saturated length handed to the embed core
  typedef struct packed {
    logic [MSG_W-1:0] msg;
    logic [LEN_W-1:0] len;
  } cfg_t;

endpackage

`default_nettype wire

>>> rtl/core/f3ce_stream_if.sv
// ----------------------------------------------------------------------------
// f3ce stream interfaces
// valid/ready channels for coefficient items in and embedded results out
// ----------------------------------------------------------------------------
`default_nettype none

interface f3ce_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [f3ce_pkg::COEFF_W-1:0]  coefficient_in;
  logic                                 start_of_image;

  modport source (output valid, output coefficient_in, output start_of_image,
                  input ready);
  modport sink   (input valid, input coefficient_in, input start_of_image,
                  output ready);
endinterface

interface f3ce_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [f3ce_pkg::COEFF_W-1:0]  coefficient_out;
  logic                                 bit_embedded;
  logic                                 shrunk_to_zero;
  logic                                 message_done;

  modport source (output valid, output coefficient_out, output bit_embedded,
                  output shrunk_to_zero, output message_done, input ready);
  modport sink   (input valid, input coefficient_out, input bit_embedded,
                  input shrunk_to_zero, input message_done, output ready);
endinterface

`default_nettype wire

>>> rtl/core/f3_coefficient_embedder_top.sv
// ----------------------------------------------------------------------------
// f3_coefficient_embedder_top
// embeds message bits into quantized dct coefficients with the f3 rule
// ----------------------------------------------------------------------------
// coef_in carries one coefficient item per valid/ready handshake, with
// start_of_image marking the first coefficient of a new image; coef_out
// returns one result item per input item, in order.
// the message (up to 32 bytes) and its length must be written through the
// wr_en/wr_index/wr_data port while no item is in flight (not enforced by the
// block); index 0..3 are the message words, index 4 the byte count, other
// indexes are ignored. an accepted input is loaded into the input register,
// then into the result register, from which the receiver takes it;
// throughput is one item per cycle, sustained as long as the receiver takes
// results.
// when the receiver stalls, the result register holds and the input register
// fills, then coef_in.ready drops; no item is lost or repeated.
// rst (synchronous, active high) clears the config registers and the embedding
// position, empties both stages and restarts embedding at byte 0, msb first.
// ----------------------------------------------------------------------------
`default_nettype none

module f3_coefficient_embedder_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            wr_en,
  input  wire logic [f3ce_pkg::CFG_IDX_W-1:0]  wr_index,
  input  wire logic [f3ce_pkg::WORD_W-1:0]     wr_data,
  f3ce_in_if.sink                              coef_in,
  f3ce_out_if.source                           coef_out
);

  f3ce_pkg::cfg_t cfg;

  f3ce_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  f3ce_embed_core u_embed_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .coef_in  (coef_in),
    .coef_out (coef_out)
  );

endmodule

`default_nettype wire

>>> rtl/core/f3ce_cfg_regs.sv
// ----------------------------------------------------------------------------
// f3ce_cfg_regs
// message words and length register with write decode and length saturation
// ----------------------------------------------------------------------------
`default_nettype none

module f3ce_cfg_regs (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  wr_en,
  input  wire logic [f3ce_pkg::CFG_IDX_W-1:0]        wr_index,
  input  wire logic [f3ce_pkg::WORD_W-1:0]           wr_data,
  output f3ce_pkg::cfg_t                             cfg
);

  logic [f3ce_pkg::WORD_W-1:0] msg_word [f3ce_pkg::NUM_WORDS];
  logic [f3ce_pkg::LEN_W-1:0]  length;
  f3ce_pkg::cfg_reg_t          wr_reg;

  assign wr_reg = f3ce_pkg::cfg_reg_t'(wr_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < f3ce_pkg::NUM_WORDS; i++) begin
        msg_word[i] <= '0;
      end
      length <= '0;
    end else if (wr_en) begin
      unique case (wr_reg)
        f3ce_pkg::REG_WORD0:  msg_word[0] <= wr_data;
        f3ce_pkg::REG_WORD1:  msg_word[1] <= wr_data;
        f3ce_pkg::REG_WORD2:  msg_word[2] <= wr_data;
        f3ce_pkg::REG_WORD3:  msg_word[3] <= wr_data;
        f3ce_pkg::REG_LENGTH: length      <= wr_data[f3ce_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.msg = {msg_word[3], msg_word[2], msg_word[1], msg_word[0]};

  // lengths above the message store are clamped
  assign cfg.len = (length > f3ce_pkg::LEN_W'(f3ce_pkg::MAX_MSG_BYTES))
                   ? f3ce_pkg::LEN_W'(f3ce_pkg::MAX_MSG_BYTES) : length;

endmodule

`default_nettype wire

>>> rtl/core/f3ce_embed_core.sv
// ----------------------------------------------------------------------------
// f3ce_embed_core
// input register, f3 embedding rule with bit/byte pointers, result register
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module f3ce_embed_core (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire f3ce_pkg::cfg_t cfg,
  f3ce_in_if.sink        coef_in,
  f3ce_out_if.source     coef_out
);

  localparam int CW = f3ce_pkg::COEFF_W;

  // input stage
  logic                   s1_valid;
  logic signed [CW-1:0]   s1_coef;
  logic                   s1_start;

  // embedding position
  logic [f3ce_pkg::LEN_W-1:0]     byte_pos;
  logic [f3ce_pkg::BIT_POS_W-1:0] bit_pos;
  logic                           finished;

  // result stage
  logic                   out_valid;
  logic signed [CW-1:0]   out_coef;
  logic                   out_emb;
  logic                   out_zero;
  logic                   out_done;

  logic s1_ready, s2_ready, s2_load;

  logic [f3ce_pkg::LEN_W-1:0]     byte_base, byte_inc, byte_pos_next;
  logic [f3ce_pkg::BIT_POS_W-1:0] bit_base, bit_pos_next;
  logic                           fin_pre, finished_next;
  logic                           msg_bit, nonzero, negative, mag_one, active;
  logic                           emb, zeroed;
  logic signed [CW-1:0]           coef_next;

  assign s2_ready      = !out_valid || coef_out.ready;
  assign s1_ready      = !s1_valid || s2_ready;
  assign s2_load       = s1_valid && s2_ready;
  assign coef_in.ready = s1_ready;

  always_comb begin
    byte_base = s1_start ? '0 : byte_pos;
    bit_base  = s1_start ? '0 : bit_pos;
    fin_pre   = (s1_start ? 1'b0 : finished) || (byte_base >= cfg.len);

    // bit position 0 means the byte's msb
    msg_bit  = cfg.msg[{byte_base[f3ce_pkg::BYTE_IDX_W-1:0], ~bit_base}];
    nonzero  = (s1_coef != '0);
    negative = s1_coef[CW-1];
    mag_one  = (s1_coef == CW'(1)) || (s1_coef == '1);
    active   = !fin_pre && nonzero;

    emb       = 1'b0;
    zeroed    = 1'b0;
    coef_next = s1_coef;
    if (active) begin
      if (s1_coef[0] == msg_bit) begin
        emb = 1'b1;
      end else if (mag_one) begin
        zeroed    = 1'b1;
        coef_next = '0;
      end else begin
        emb       = 1'b1;
        coef_next = negative ? s1_coef + CW'(1) : s1_coef - CW'(1);
      end
    end

    byte_inc      = byte_base + f3ce_pkg::LEN_W'(1);
    bit_pos_next  = bit_base;
    byte_pos_next = byte_base;
    finished_next = fin_pre;
    if (emb) begin
      bit_pos_next = bit_base + f3ce_pkg::BIT_POS_W'(1);
      if (bit_base == '1) begin
        byte_pos_next = byte_inc;
        finished_next = (byte_inc >= cfg.len);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      byte_pos  <= '0;
      bit_pos   <= '0;
      finished  <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= coef_in.valid;
      end
      if (s2_ready) begin
        out_valid <= s1_valid;
      end
      if (s2_load) begin
        byte_pos <= byte_pos_next;
        bit_pos  <= bit_pos_next;
        finished <= finished_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && coef_in.valid) begin
      s1_coef  <= coef_in.coefficient_in;
      s1_start <= coef_in.start_of_image;
    end
    if (s2_load) begin
      out_coef <= coef_next;
      out_emb  <= emb;
      out_zero <= zeroed;
      out_done <= finished_next;
    end
  end

  assign coef_out.valid           = out_valid;
  assign coef_out.coefficient_out = out_coef;
  assign coef_out.bit_embedded    = out_emb;
  assign coef_out.shrunk_to_zero  = out_zero;
  assign coef_out.message_done    = out_done;

  `ASSERT_IMPLIES(a_emb_zero_excl, clk, rst, out_valid, !(out_emb && out_zero))
  `ASSERT_IMPLIES(a_zeroed_is_zero, clk, rst, out_valid && out_zero, out_coef == '0)
  `ASSERT_NEXT(a_idle_passes, clk, rst, s2_load && !emb && !zeroed,
               out_coef == $past(s1_coef))
  `ASSERT_NEXT(a_finished_sticks, clk, rst, s2_load && finished && !s1_start,
               finished && out_done)

endmodule

`default_nettype wire
